>>> hw/rtl/uitp_pkg.sv
package uitp_pkg;

    localparam int COUNT_BITS = 16;

    localparam logic [5:0] RADIX_RESET = 6'd10;

    // bases
    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_MIN  = 6'd2;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;
    localparam logic [5:0] BASE_MAX  = 6'd36;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] NOT_DIGIT = 8'hFF;

    typedef enum logic [4:0] {
        PH_SKIP       = 5'b00001,
        PH_AFTER_SIGN = 5'b00010,
        PH_SAW_ZERO   = 5'b00100,
        PH_DIGITS     = 5'b01000,
        PH_DONE       = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [5:0]  base;
        logic [63:0] acc;
        logic        ovf;
        logic        any_digit;
    } parse_state_t;

    typedef struct packed {
        logic [15:0] consumed;
        logic [63:0] value;
        logic [1:0]  status;
    } parse_result_t;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            d = c - CH_ZERO;
        end else if (c inside {[CH_LOW_A:CH_LOW_Z]}) begin
            d = c - CH_LOW_A + 8'd10;
        end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
            d = c - CH_UP_A + 8'd10;
        end else begin
            d = NOT_DIGIT;
        end
        return d;
    endfunction

endpackage

>>> hw/rtl/unsigned_integer_text_parser.sv
// channel | direction | handshake              | payload
// s_      | in        | s_tvalid / s_tready    | s_tdata: ch, s_tuser: starts_string
// m_      | out       | m_tvalid / m_tready    | m_tdata: status, value, consumed
// cfg_    | in        | cfg_valid / cfg_ready  | cfg_data: radix
//
// one item per cycle sustained while the output is not stalled; an item waits in the input
// register and its result, if any, is registered in the output register when the item fires.
// the 64 by 6 bit multiply-add of the digit step sets the cycle time.
// aresetn is synchronous, active low; radix resets to 10 and the parse restarts.
// a stalled output holds the input register, and s_tready drops only then.
module unsigned_integer_text_parser #(
    parameter int COUNT_BITS = uitp_pkg::COUNT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] starts_string

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [1:0] status, [65:2] value, [81:66] consumed, zero pad

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    logic [5:0]             radix_reg;

    logic                   in_valid_reg;
    logic [7:0]             in_ch_reg;
    logic                   in_start_reg;

    uitp_pkg::parse_state_t  state_reg;
    uitp_pkg::parse_state_t  state_next;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;

    logic                    out_valid_reg;
    uitp_pkg::parse_result_t out_res_reg;

    logic                    emit;
    uitp_pkg::parse_result_t res;
    logic                    fire;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'd0, out_res_reg};

    uitp_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .cur       (state_reg),
        .cur_count (count_reg),
        .ch        (in_ch_reg),
        .starts    (in_start_reg),
        .radix     (radix_reg),
        .nxt       (state_next),
        .nxt_count (count_next),
        .emit      (emit),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg           <= uitp_pkg::RADIX_RESET;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            state_reg.phase     <= uitp_pkg::PH_SKIP;
            state_reg.base      <= uitp_pkg::BASE_AUTO;
            state_reg.acc       <= '0;
            state_reg.ovf       <= 1'b0;
            state_reg.any_digit <= 1'b0;
            count_reg           <= '0;
        end else begin
            if (cfg_valid) begin
                radix_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
            if (fire && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg    <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (fire && emit) begin
            out_res_reg <= res;
        end
    end

endmodule

>>> hw/rtl/uitp_step.sv
module uitp_step #(
    parameter int COUNT_BITS = uitp_pkg::COUNT_BITS
) (
    input  uitp_pkg::parse_state_t  cur,
    input  logic [COUNT_BITS-1:0]   cur_count,
    input  logic [7:0]              ch,
    input  logic                    starts,
    input  logic [5:0]              radix,
    output uitp_pkg::parse_state_t  nxt,
    output logic [COUNT_BITS-1:0]   nxt_count,
    output logic                    emit,
    output uitp_pkg::parse_result_t res
);

    localparam int WIDE_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    function automatic logic [COUNT_BITS-1:0] count_inc(
        input logic [COUNT_BITS-1:0] c,
        input logic [1:0]            n
    );
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, c} + (COUNT_BITS + 1)'(n);
        return sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    endfunction

    function automatic logic [15:0] to_consumed(input logic [COUNT_BITS-1:0] c);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(c);
        return (w > WIDE_BITS'(17'h0FFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    uitp_pkg::parse_state_t s;
    logic [COUNT_BITS-1:0]  s_count;
    logic [7:0]             digit;
    logic                   settle;
    logic                   td_en;
    logic [5:0]             td_base;
    logic                   td_any;
    logic [COUNT_BITS-1:0]  td_count;
    logic [70:0]            prod;

    assign digit = uitp_pkg::digit_value(ch);

    always_comb begin
        s       = cur;
        s_count = cur_count;
        if (starts) begin
            s.phase     = uitp_pkg::PH_SKIP;
            s.base      = uitp_pkg::BASE_AUTO;
            s.acc       = '0;
            s.ovf       = 1'b0;
            s.any_digit = 1'b0;
            s_count     = '0;
        end

        nxt       = s;
        nxt_count = s_count;
        emit      = 1'b0;
        res       = '0;
        settle    = 1'b0;
        td_en     = 1'b0;
        td_base   = s.base;
        td_any    = s.any_digit;
        td_count  = s_count;
        prod      = '0;

        case (s.phase)
            uitp_pkg::PH_SKIP: begin
                if (ch == uitp_pkg::CH_SPACE || ch == uitp_pkg::CH_TAB) begin
                    nxt_count = count_inc(s_count, 2'd1);
                end else if (ch == uitp_pkg::CH_PLUS) begin
                    nxt_count = count_inc(s_count, 2'd1);
                    nxt.phase = uitp_pkg::PH_AFTER_SIGN;
                end else begin
                    settle = 1'b1;
                end
            end
            uitp_pkg::PH_AFTER_SIGN: begin
                settle = 1'b1;
            end
            uitp_pkg::PH_SAW_ZERO: begin
                if (ch == uitp_pkg::CH_LOW_X || ch == uitp_pkg::CH_UP_X) begin
                    nxt.base  = uitp_pkg::BASE_HEX;
                    nxt.phase = uitp_pkg::PH_DIGITS;
                    nxt_count = count_inc(s_count, 2'd2);
                end else begin
                    // the leading zero counts as a digit
                    td_en    = 1'b1;
                    td_base  = (s.base == uitp_pkg::BASE_AUTO) ?
                               uitp_pkg::BASE_OCT : uitp_pkg::BASE_HEX;
                    td_any   = 1'b1;
                    td_count = count_inc(s_count, 2'd1);
                end
            end
            uitp_pkg::PH_DIGITS: begin
                td_en = 1'b1;
            end
            default: begin
            end
        endcase

        if (settle) begin
            if ((radix == uitp_pkg::BASE_AUTO || radix == uitp_pkg::BASE_HEX) &&
                ch == uitp_pkg::CH_ZERO) begin
                nxt.base  = radix;
                nxt.phase = uitp_pkg::PH_SAW_ZERO;
            end else if (radix == uitp_pkg::BASE_AUTO) begin
                td_en   = 1'b1;
                td_base = uitp_pkg::BASE_DEC;
            end else if (radix < uitp_pkg::BASE_MIN || radix > uitp_pkg::BASE_MAX) begin
                emit         = 1'b1;
                res.status   = uitp_pkg::ST_INVALID;
                res.consumed = to_consumed(s_count);
                nxt.phase    = uitp_pkg::PH_DONE;
            end else begin
                td_en   = 1'b1;
                td_base = radix;
            end
        end

        if (td_en) begin
            nxt.base      = td_base;
            nxt.phase     = uitp_pkg::PH_DIGITS;
            nxt.any_digit = td_any;
            nxt_count     = td_count;
            if (td_base < uitp_pkg::BASE_MIN || td_base > uitp_pkg::BASE_MAX ||
                digit >= {2'b00, td_base}) begin
                emit      = 1'b1;
                nxt.phase = uitp_pkg::PH_DONE;
                if (!td_any) begin
                    res.status = uitp_pkg::ST_INVALID;
                end else if (s.ovf) begin
                    res.status   = uitp_pkg::ST_OVERFLOW;
                    res.value    = '1;
                    res.consumed = to_consumed(td_count);
                end else begin
                    res.status   = uitp_pkg::ST_OK;
                    res.value    = s.acc;
                    res.consumed = to_consumed(td_count);
                end
            end else begin
                // overflow when the product spills past 64 bits
                prod = 71'(s.acc) * 71'(td_base) + 71'(digit);
                if (!s.ovf) begin
                    if (prod[70:64] != 7'd0) begin
                        nxt.ovf = 1'b1;
                        nxt.acc = '1;
                    end else begin
                        nxt.acc = prod[63:0];
                    end
                end
                nxt.any_digit = 1'b1;
                nxt_count     = count_inc(td_count, 2'd1);
            end
        end
    end

endmodule
